[rtl/ctns_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_pkg
// shared types and constants of the calibrated counter-to-ns converter
// ----------------------------------------------------------------------------
package ctns_pkg;

    localparam logic [1:0] CMD_CAL   = 2'd0;
    localparam logic [1:0] CMD_CONV  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] ctr_start;
        logic [63:0] ctr_end;
        logic [63:0] ref_start_ns;
        logic [63:0] ref_end_ns;
        logic [63:0] base_ctr;
        logic [63:0] base_ref_ns;
        logic [63:0] now_ctr;
    } item_t;

    typedef struct packed {
        logic [63:0] time_ns;
        logic        time_valid;
        logic        cal_ok;
        logic [63:0] freq_hz;
    } result_t;

    // dividend / divisor pairs
    typedef enum logic [1:0] {
        DIV_SRC_WINDOW,
        DIV_SRC_ACC,
        DIV_SRC_NUMER
    } div_src_t;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MUL_SRC_QUO,
        MUL_SRC_REM,
        MUL_SRC_CONV
    } mul_src_t;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_OK,
        RES_CONV
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      div_load;
        div_src_t  div_src;
        logic      div_step;
        logic      mul_load;
        mul_src_t  mul_src;
        logic      mul_issue;
        logic [1:0] mul_idx;
        logic      acc_add;
        logic      save_part;
        logic      set_freq;
        logic      set_mult;
        logic      set_base;
        logic      clear;
        logic      out_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       window_zero;
        logic       freq_zero;
        logic       quo_zero;
        logic       conv_ready;
    } dp_stat_t;

endpackage
`default_nettype wire

[rtl/counter_to_ns_calibrated_converter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// counter_to_ns_calibrated_converter_top
// calibrates a cycle counter against a ns reference and converts readings
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  item     | item_valid / item_stall      | item_t: cmd, window, base, now
//  result   | result_valid / result_stall  | result_t: time_ns, flags, freq
//
//  convert: decode with operand load, five multiply steps (four 32x32 partial
//  products through one shared multiplier, the last added a step later),
//  result load; the next item is taken once the result is loaded
//  calibrate: three 64-step divisions on one radix-2 divider and two 64x64
//  products on the same multiplier; an empty window skips all of them and a
//  zero frequency skips the third division
//  clear, an unused command or an uncalibrated convert go from decode
//  straight to result load
//  reset clears the calibration state; a result waiting on result_stall
//  holds and the next item may still be taken meanwhile
// ----------------------------------------------------------------------------
module counter_to_ns_calibrated_converter_top
    import ctns_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    // command and status between sequencer and datapath
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer owns handshakes and the step counter
    ctns_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (dp_stat),
        .cmd          (dp_cmd)
    );

    // datapath holds stored calibration and the arithmetic units
    ctns_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (dp_cmd),
        .stat   (dp_stat),
        .result (result)
    );

endmodule
`default_nettype wire

[rtl/ctns_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_ctrl
// sequencer: decodes items and steps the shared divider and multiplier
// ----------------------------------------------------------------------------
module ctns_ctrl
    import ctns_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  wire logic     result_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [5:0] DIV_LAST = 6'd63;
    localparam logic [5:0] MUL_LAST = 6'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_A,
        S_MUL_Q_LD,
        S_MUL_Q,
        S_SAVE,
        S_MUL_R,
        S_DIV_B_LD,
        S_DIV_B,
        S_FREQ,
        S_FCHK,
        S_DIV_C,
        S_MSET,
        S_MUL_C,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    res_kind_t  res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    logic       mul_phase, div_phase;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.res_kind   = res_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        mul_phase = (state_reg inside {S_MUL_Q, S_MUL_R, S_MUL_C});
        div_phase = (state_reg inside {S_DIV_A, S_DIV_B, S_DIV_C});

        // partial product i issued in step i, added one step later
        if (mul_phase)
        begin
            cmd.mul_issue = (cnt_reg != MUL_LAST);
            cmd.mul_idx   = cnt_reg[1:0];
            cmd.acc_add   = (cnt_reg != 6'd0);
            cnt_next      = cnt_reg + 6'd1;
        end
        if (div_phase)
        begin
            cmd.div_step = 1'b1;
            cnt_next     = cnt_reg + 6'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next   = RES_PLAIN;
                state_next = S_OUT;
                case (stat.cmd)
                    CMD_CAL:
                    begin
                        if (!stat.window_zero)
                        begin
                            cmd.div_load = 1'b1;
                            cmd.div_src  = DIV_SRC_WINDOW;
                            cnt_next     = '0;
                            state_next   = S_DIV_A;
                        end
                    end
                    CMD_CONV:
                    begin
                        if (stat.conv_ready)
                        begin
                            cmd.mul_load = 1'b1;
                            cmd.mul_src  = MUL_SRC_CONV;
                            cnt_next     = '0;
                            state_next   = S_MUL_C;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                        res_next = RES_PLAIN;
                    end
                endcase
            end
            S_DIV_A:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_MUL_Q_LD;
                end
            end
            // quotient settles on the last divider step, load it after
            S_MUL_Q_LD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_src  = MUL_SRC_QUO;
                cnt_next     = '0;
                state_next   = S_MUL_Q;
            end
            S_MUL_Q:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_SAVE;
                end
            end
            S_SAVE:
            begin
                cmd.save_part = 1'b1;
                cmd.mul_load  = 1'b1;
                cmd.mul_src   = MUL_SRC_REM;
                cnt_next      = '0;
                state_next    = S_MUL_R;
            end
            S_MUL_R:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_DIV_B_LD;
                end
            end
            S_DIV_B_LD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_ACC;
                cnt_next     = '0;
                state_next   = S_DIV_B;
            end
            S_DIV_B:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FREQ;
                end
            end
            S_FREQ:
            begin
                cmd.set_freq = 1'b1;
                state_next   = S_FCHK;
            end
            S_FCHK:
            begin
                if (stat.freq_zero)
                begin
                    res_next   = RES_PLAIN;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = DIV_SRC_NUMER;
                    cnt_next     = '0;
                    state_next   = S_DIV_C;
                end
            end
            S_DIV_C:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_MSET;
                end
            end
            S_MSET:
            begin
                cmd.set_mult = 1'b1;
                if (stat.quo_zero)
                begin
                    res_next = RES_PLAIN;
                end
                else
                begin
                    cmd.set_base = 1'b1;
                    res_next     = RES_OK;
                end
                state_next = S_OUT;
            end
            S_MUL_C:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    res_next   = RES_CONV;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_reg       <= RES_PLAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[rtl/ctns_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_dp
// datapath: calibration state, radix-2 divider, 32x32 multiplier, result
// ----------------------------------------------------------------------------
module ctns_dp
    import ctns_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire dp_cmd_t cmd,
    output dp_stat_t     stat,
    output result_t      result
);

    localparam logic [63:0] NUMER = NS_PER_SEC << FRAC_BITS;

    item_t        item_reg;
    logic [63:0]  freq_reg, mult_reg, base_count_reg, base_time_reg;
    logic [63:0]  div_quo_reg, div_rem_reg, div_dvs_reg;
    logic [63:0]  mul_a_reg, mul_b_reg, prod_reg, part_reg;
    logic [1:0]   prod_shift_reg;
    logic [127:0] acc_reg;
    result_t      result_reg;

    logic [63:0]  d_ctr, d_ns, freq_sum;
    logic [64:0]  rem_ext, rem_diff;
    logic         div_bit;
    logic [31:0]  mul_a_half, mul_b_half;
    logic [127:0] prod_aligned;
    logic [63:0]  conv_ns;

    assign d_ctr    = item_reg.ctr_end - item_reg.ctr_start;
    assign d_ns     = item_reg.ref_end_ns - item_reg.ref_start_ns;
    assign freq_sum = part_reg + div_quo_reg;

    assign stat.cmd         = item_reg.cmd;
    assign stat.window_zero = (d_ctr == 64'd0) || (d_ns == 64'd0);
    assign stat.freq_zero   = (freq_reg == 64'd0);
    assign stat.quo_zero    = (div_quo_reg == 64'd0);
    assign stat.conv_ready  = (freq_reg != 64'd0) && (mult_reg != 64'd0);

    // one restoring step: shift in next dividend bit, try the subtract
    assign rem_ext  = {div_rem_reg, div_quo_reg[63]};
    assign rem_diff = rem_ext - {1'b0, div_dvs_reg};
    assign div_bit  = !rem_diff[64];

    assign mul_a_half = cmd.mul_idx[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign mul_b_half = cmd.mul_idx[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];

    always_comb
    begin
        case (prod_shift_reg)
            2'd0:    prod_aligned = {64'd0, prod_reg};
            2'd1:    prod_aligned = {32'd0, prod_reg, 32'd0};
            2'd2:    prod_aligned = {prod_reg, 64'd0};
            default: prod_aligned = '0;
        endcase
    end

    assign conv_ns = base_time_reg + acc_reg[FRAC_BITS +: 64];

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end

        if (cmd.div_load)
        begin
            div_rem_reg <= '0;
            case (cmd.div_src)
                DIV_SRC_WINDOW:
                begin
                    div_quo_reg <= d_ctr;
                    div_dvs_reg <= d_ns;
                end
                DIV_SRC_ACC:
                begin
                    div_quo_reg <= acc_reg[63:0];
                    div_dvs_reg <= d_ns;
                end
                default:
                begin
                    div_quo_reg <= NUMER + (freq_reg >> 1);
                    div_dvs_reg <= freq_reg;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_bit ? rem_diff[63:0] : rem_ext[63:0];
            div_quo_reg <= {div_quo_reg[62:0], div_bit};
        end

        if (cmd.mul_load)
        begin
            case (cmd.mul_src)
                MUL_SRC_QUO:
                begin
                    mul_a_reg <= div_quo_reg;
                    mul_b_reg <= NS_PER_SEC;
                end
                MUL_SRC_REM:
                begin
                    mul_a_reg <= div_rem_reg;
                    mul_b_reg <= NS_PER_SEC;
                end
                default:
                begin
                    mul_a_reg <= item_reg.now_ctr - base_count_reg;
                    mul_b_reg <= mult_reg;
                end
            endcase
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_aligned;
        end

        if (cmd.mul_issue)
        begin
            prod_reg       <= {32'd0, mul_a_half} * {32'd0, mul_b_half};
            prod_shift_reg <= {1'b0, cmd.mul_idx[1]} + {1'b0, cmd.mul_idx[0]};
        end

        if (cmd.save_part)
        begin
            part_reg <= acc_reg[63:0];
        end

        if (cmd.out_load)
        begin
            result_reg.freq_hz    <= freq_reg;
            result_reg.cal_ok     <= (cmd.res_kind == RES_OK);
            result_reg.time_valid <= (cmd.res_kind == RES_CONV);
            result_reg.time_ns    <= (cmd.res_kind == RES_CONV) ? conv_ns : 64'd0;
        end
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg       <= '0;
            mult_reg       <= '0;
            base_count_reg <= '0;
            base_time_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            freq_reg       <= '0;
            mult_reg       <= '0;
            base_count_reg <= '0;
            base_time_reg  <= '0;
        end
        else
        begin
            if (cmd.set_freq)
            begin
                freq_reg <= freq_sum;
            end
            if (cmd.set_mult)
            begin
                mult_reg <= div_quo_reg;
            end
            if (cmd.set_base)
            begin
                base_count_reg <= item_reg.base_ctr;
                base_time_reg  <= item_reg.base_ref_ns;
            end
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

[bench/counter_to_ns_calibrated_converter_top_test.sv]
// ----------------------------------------------------------------------------
// counter_to_ns_calibrated_converter_top_test
// checks calibration and counter-to-ns conversion against a local predictor
// a table of directed items comes first, some with typed-in results, then
// random calibrate, convert, clear and unused items under random idling
// ----------------------------------------------------------------------------
module counter_to_ns_calibrated_converter_top_test;
    import ctns_pkg::*;

    localparam int FRAC_BITS = 32;

    // the package names three commands, the fourth is left unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 880;
    localparam int QUIET_TAIL     = 100;   // last random items run without idling
    localparam int DRAIN_CYCLES   = 250;   // drain margin, longer than a calibrate takes
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [63:0] ALL_ONES = '1;

    typedef struct {
        item_t   it;
        bit      known;
        result_t want;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // typed-in expectation that travels alongside the item being offered
    logic    row_known = 1'b0;
    result_t row_want = '0;

    // predictor copy of the calibration state
    logic [63:0] cal_freq = '0;
    logic [63:0] cal_mult = '0;
    logic [63:0] cal_base_ctr = '0;
    logic [63:0] cal_base_ns = '0;

    result_t   readings_due[$];
    stim_row_t directed_rows[$];

    int  failures = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    always #4 clk = ~clk;

    counter_to_ns_calibrated_converter_top #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // predictor: one reading per accepted item, state updated as it goes
    // ------------------------------------------------------------------------
    function automatic result_t predict_reading(item_t it);
        result_t      r;
        logic [63:0]  d_ctr;
        logic [63:0]  d_ns;
        logic [63:0]  quo;
        logic [63:0]  rem;
        logic [63:0]  freq;
        logic [63:0]  mult;
        logic [127:0] prod;
        r = '0;
        case (it.cmd)
            CMD_CAL:
            begin
                d_ctr = it.ctr_end - it.ctr_start;
                d_ns  = it.ref_end_ns - it.ref_start_ns;
                // empty window leaves everything untouched
                if (d_ctr != 0 && d_ns != 0)
                begin
                    // quotient and remainder parts, each step wraps at 64 bits
                    quo  = d_ctr / d_ns;
                    rem  = d_ctr % d_ns;
                    freq = quo * NS_PER_SEC + (rem * NS_PER_SEC) / d_ns;
                    cal_freq = freq;
                    if (freq != 0)
                    begin
                        // rounded ns per tick, the sum may wrap
                        mult = ((NS_PER_SEC << FRAC_BITS) + (freq >> 1)) / freq;
                        cal_mult = mult;
                        if (mult != 0)
                        begin
                            cal_base_ctr = it.base_ctr;
                            cal_base_ns  = it.base_ref_ns;
                            r.cal_ok = 1'b1;
                        end
                    end
                end
            end
            CMD_CONV:
            begin
                if (cal_freq != 0 && cal_mult != 0)
                begin
                    prod = {64'd0, it.now_ctr - cal_base_ctr} * {64'd0, cal_mult};
                    r.time_ns    = cal_base_ns + prod[FRAC_BITS +: 64];
                    r.time_valid = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                cal_freq     = '0;
                cal_mult     = '0;
                cal_base_ctr = '0;
                cal_base_ns  = '0;
            end
            default:
            begin
            end
        endcase
        r.freq_hz = cal_freq;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t cal_item(logic [63:0] cs, logic [63:0] ce, logic [63:0] rs,
                                       logic [63:0] re, logic [63:0] bc, logic [63:0] bn);
        item_t it;
        it = '0;
        it.cmd          = CMD_CAL;
        it.ctr_start    = cs;
        it.ctr_end      = ce;
        it.ref_start_ns = rs;
        it.ref_end_ns   = re;
        it.base_ctr     = bc;
        it.base_ref_ns  = bn;
        return it;
    endfunction

    function automatic item_t conv_item(logic [63:0] now);
        item_t it;
        it = '0;
        it.cmd     = CMD_CONV;
        it.now_ctr = now;
        return it;
    endfunction

    // every field set to ones, so ignored fields cannot leak into state
    function automatic item_t filled_item(logic [1:0] cmd);
        item_t it;
        it = '1;
        it.cmd = cmd;
        return it;
    endfunction

    function automatic result_t reading(logic [63:0] t, logic v, logic ok, logic [63:0] f);
        result_t r;
        r.time_ns    = t;
        r.time_valid = v;
        r.cal_ok     = ok;
        r.freq_hz    = f;
        return r;
    endfunction

    function automatic void add_row(item_t it, bit known, result_t want);
        stim_row_t row;
        row.it    = it;
        row.known = known;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // mostly plausible calibrations and conversions near the base, plus noise
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        logic [63:0] d_ns;
        logic [63:0] freq;
        it.ctr_start    = rand64();
        it.ctr_end      = rand64();
        it.ref_start_ns = rand64();
        it.ref_end_ns   = rand64();
        it.base_ctr     = rand64();
        it.base_ref_ns  = rand64();
        it.now_ctr      = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            it.cmd = CMD_CAL;
            d_ns = 64'($urandom_range(1, 2000000000));
            freq = 64'($urandom_range(1000, 2000000000)) * 64'($urandom_range(1, 3));
            it.ctr_end     = it.ctr_start + freq * d_ns / NS_PER_SEC;
            it.ref_end_ns  = it.ref_start_ns + d_ns;
            it.base_ctr    = it.ctr_end + 64'($urandom_range(0, 1000));
            it.base_ref_ns = it.ref_end_ns + 64'($urandom_range(0, 1000));
        end
        else if (pick < 24)
        begin
            // raw windows, sometimes nearly or fully empty
            it.cmd = CMD_CAL;
            if ($urandom_range(0, 1) == 0)
                it.ctr_end = it.ctr_start + 64'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
                it.ref_end_ns = it.ref_start_ns + 64'($urandom_range(0, 3));
        end
        else if (pick < 28)
            it.cmd = CMD_CLEAR;
        else if (pick < 31)
            it.cmd = CMD_UNUSED;
        else
        begin
            it.cmd = CMD_CONV;
            case ($urandom_range(0, 3))
                0: it.now_ctr = rand64();
                1: it.now_ctr = cal_base_ctr - 64'($urandom_range(0, 1000000));
                default: it.now_ctr = cal_base_ctr + 64'($urandom) * 64'($urandom_range(0, 255));
            endcase
        end
        return it;
    endfunction

    // offer one item and hold it until the transfer happens
    task automatic send_item(item_t it, bit known, result_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item       <= it;
        row_known  <= known;
        row_want   <= want;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic check_reading(result_t got);
        result_t want;
        if (readings_due.size() == 0)
        begin
            $display("%0t: unexpected result time_ns %h valid %b ok %b freq %h",
                     $time, got.time_ns, got.time_valid, got.cal_ok, got.freq_hz);
            failures++;
        end
        else
        begin
            want = readings_due.pop_front();
            if (got.time_ns !== want.time_ns)
            begin
                $display("%0t: time_ns expected %h actual %h", $time, want.time_ns, got.time_ns);
                failures++;
            end
            if (got.time_valid !== want.time_valid)
            begin
                $display("%0t: time_valid expected %b actual %b",
                         $time, want.time_valid, got.time_valid);
                failures++;
            end
            if (got.cal_ok !== want.cal_ok)
            begin
                $display("%0t: cal_ok expected %b actual %b", $time, want.cal_ok, got.cal_ok);
                failures++;
            end
            if (got.freq_hz !== want.freq_hz)
            begin
                $display("%0t: freq_hz expected %h actual %h", $time, want.freq_hz, got.freq_hz);
                failures++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // item side monitor: every transfer gets its expected reading queued,
    // the typed-in one for known table rows, the predicted one otherwise
    // the predictor runs on every item so its state stays in step
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && item_valid && !item_stall)
        begin
            r = predict_reading(item);
            if (row_known)
                r = row_want;
            readings_due.push_back(r);
        end
    end

    // result side monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_reading(result);
    end

    // result stall in random bursts, none in the quiet tail
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0)
            stall_left--;
        else if (!result_stall && $urandom_range(0, 3) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
            result_stall <= 1'b0;
    end

    // watchdog on cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        // uncalibrated convert at the top of the counter range
        add_row(conv_item(ALL_ONES), 1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        // empty windows: no counter movement, then no ns movement
        add_row(cal_item(64'd5, 64'd5, 64'd0, 64'd1000, 64'd1, 64'd1),
                1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        add_row(cal_item(64'd0, 64'd1000, 64'd7, 64'd7, 64'd1, 64'd1),
                1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        // exactly 1 GHz, one ns per tick
        add_row(cal_item(64'd0, NS_PER_SEC, 64'd0, NS_PER_SEC, 64'd100, 64'd5000),
                1'b1, reading(64'd0, 1'b0, 1'b1, NS_PER_SEC));
        add_row(conv_item(64'd1100), 1'b1, reading(64'd6000, 1'b1, 1'b0, NS_PER_SEC));
        // readings below the base wrap around
        add_row(conv_item(64'd0), 1'b0, '0);
        add_row(conv_item(ALL_ONES), 1'b0, '0);
        add_row(filled_item(CMD_UNUSED), 1'b1, reading(64'd0, 1'b0, 1'b0, NS_PER_SEC));
        // frequency rounds down to zero, conversions turn invalid
        add_row(cal_item(64'd0, 64'd1, 64'd0, 64'd10000000000, 64'd9, 64'd9),
                1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        add_row(conv_item(64'd12345), 1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        // 3 GHz with the base at the top of the range
        add_row(cal_item(64'd0, 64'd3000000000, 64'd0, NS_PER_SEC, ALL_ONES, ALL_ONES),
                1'b0, '0);
        add_row(conv_item(64'd0), 1'b0, '0);
        // full-range counter delta over one second, multiplier rounds to zero
        add_row(cal_item(64'd1, 64'd0, 64'd0, NS_PER_SEC, 64'd3, 64'd3),
                1'b1, reading(64'd0, 1'b0, 1'b0, ALL_ONES));
        add_row(conv_item(64'd77), 1'b1, reading(64'd0, 1'b0, 1'b0, ALL_ONES));
        // window that wraps on both the counter and the reference
        add_row(cal_item(ALL_ONES - 64'd999, 64'd1000, ALL_ONES - 64'd499, 64'd500,
                         64'h8000_0000_0000_0000, 64'h0123_4567_89ab_cdef), 1'b0, '0);
        add_row(conv_item(64'h8000_0000_1234_5678), 1'b0, '0);
        add_row(filled_item(CMD_CLEAR), 1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        add_row(conv_item(64'd1100), 1'b1, reading(64'd0, 1'b0, 1'b0, 64'd0));
        // one tick per ns from the smallest window
        add_row(cal_item(64'd0, 64'd1, 64'd0, 64'd1, 64'd0, 64'd0), 1'b0, '0);
        // one tick per second, largest multiplier
        add_row(cal_item(64'd0, 64'd1, 64'd0, NS_PER_SEC, 64'd0, 64'd0), 1'b0, '0);
        add_row(conv_item(ALL_ONES), 1'b0, '0);
        // remainder times 1e9 overflows 64 bits
        add_row(cal_item(64'd0, ALL_ONES, 64'd0, 64'h0000_0100_0000_0003, 64'd0, 64'd0),
                1'b0, '0);
        add_row(conv_item(64'h0000_0000_ffff_ffff), 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].known, directed_rows[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            send_item(random_item(), 1'b0, '0);
        end
        item_valid <= 1'b0;
        row_known  <= 1'b0;

        // drain, then leave room for any stray result
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
